// ----- rtl/ssm_pkg.sv -----
// Shared types, opcodes and status codes of the sparse set membership core.
// No dependencies; used by the core, the checker and the testbench through scoped names.
`default_nettype none

package ssm_pkg;

   localparam int IDX_W        = 8;
   localparam int CNT_W        = 9;
   localparam int TABLE_DEPTH  = 256;
   localparam int CAPACITY_DEF = 256;

   localparam logic [CNT_W-1:0] ABSENT_POS = 9'd256;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_CONTAINS = 2'd2;
   localparam logic [1:0] OP_READ     = 2'd3;

   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_FULL   = 3'd1;
   localparam logic [2:0] STAT_DUP    = 3'd2;
   localparam logic [2:0] STAT_ABSENT = 3'd3;
   localparam logic [2:0] STAT_RANGE  = 3'd4;

   typedef struct packed {
      logic [1:0]       operation;
      logic [IDX_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic             present;
      logic [IDX_W-1:0] member;
      logic [CNT_W-1:0] count;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/ssm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
`default_nettype none

module ssm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sparse_set_membership_core.sv -----
// Sparse set membership core: top level.
// Depends on ssm_pkg and two ssm_ram instances (member list, position table).
//
// Keeps a set of element indices below min(CAPACITY, 256) as a packed member
// list, a per-element position table and a member count. Each accepted item
// (add, remove, contains, read member at list position) yields exactly one
// result item carrying a status, a presence flag, the read member and the
// count after the operation. Both RAMs are read on accept; EXEC then decides
// and writes back, waiting while the output register holds an untaken
// result. One item is in work at a time; a new item is taken while a
// finished result still waits in the output register. The position table's
// reset to "absent" is held in 256 valid flops cleared by reset, so no
// clearing pass is needed after reset. Duplicate adds and
// removal of absent elements are rejected with a status and change nothing.
`default_nettype none

module sparse_set_membership_core #(
   parameter int CAPACITY = ssm_pkg::CAPACITY_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire ssm_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      ssm_pkg::rsp_type rsp_data
);

   localparam int DEPTH   = ssm_pkg::TABLE_DEPTH;
   localparam int IDX_W   = ssm_pkg::IDX_W;
   localparam int CNT_W   = ssm_pkg::CNT_W;
   localparam int EFF_CAP = (CAPACITY < DEPTH) ? CAPACITY : DEPTH;
   localparam logic [CNT_W-1:0] EFF_CAP_C = CNT_W'(EFF_CAP);

   // sequencer: read phase happens on accept, EXEC waits for and does the write-back
   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic             state_ff, state_in;
   ssm_pkg::req_type req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEPTH-1:0] pos_vld_ff, pos_vld_in;
   logic             pos_vld_rd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   ssm_pkg::rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic             commit;
   logic [CNT_W-1:0] last_pos;

   // RAM ports
   logic             list_we, pos_we;
   logic [IDX_W-1:0] list_waddr, list_wdata, list_raddr, list_rdata;
   logic [IDX_W-1:0] pos_waddr;
   logic [CNT_W-1:0] pos_wdata, pos_rdata;

   // decision terms
   logic             idx_ok;
   logic             is_mem;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign last_pos  = count_ff - CNT_W'(1);

   // list read: requested position for a read, else the last member
   // (the candidate to move into a freed slot on remove)
   assign list_raddr = (req_data.operation == ssm_pkg::OP_READ) ?
                       req_data.index : last_pos[IDX_W-1:0];

   ssm_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (list_waddr),
      .wr_data (list_wdata),
      .rd_en   (accept),
      .rd_addr (list_raddr),
      .rd_data (list_rdata)
   );

   ssm_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_en   (accept),
      .rd_addr (req_data.index),
      .rd_data (pos_rdata)
   );

   assign idx_ok = {1'b0, req_ff.index} < EFF_CAP_C;
   // an entry without its valid bit reads as absent
   assign is_mem = pos_vld_rd_ff && (pos_rdata < count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_vld_in   = pos_vld_ff;
      list_we      = 1'b0;
      list_waddr   = count_ff[IDX_W-1:0];
      list_wdata   = req_ff.index;
      pos_we       = 1'b0;
      pos_waddr    = req_ff.index;
      pos_wdata    = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         state_in = S_EXEC;
      end

      if (commit) begin
         state_in       = S_IDLE;
         rsp_valid_in   = 1'b1;
         rsp_in.status  = ssm_pkg::STAT_OK;
         rsp_in.present = 1'b0;
         rsp_in.member  = '0;

         if (req_ff.operation == ssm_pkg::OP_READ) begin
            if ({1'b0, req_ff.index} < count_ff) begin
               rsp_in.member  = list_rdata;
               rsp_in.present = 1'b1;
            end else begin
               rsp_in.status = ssm_pkg::STAT_RANGE;
            end
         end else if (!idx_ok) begin
            rsp_in.status = ssm_pkg::STAT_RANGE;
         end else begin
            case (req_ff.operation)
               ssm_pkg::OP_ADD: begin
                  if (is_mem) begin
                     rsp_in.status  = ssm_pkg::STAT_DUP;
                     rsp_in.present = 1'b1;
                  end else if (count_ff >= EFF_CAP_C) begin
                     rsp_in.status = ssm_pkg::STAT_FULL;
                  end else begin
                     list_we                  = 1'b1;
                     pos_we                   = 1'b1;
                     pos_vld_in[req_ff.index] = 1'b1;
                     count_in                 = count_ff + CNT_W'(1);
                     rsp_in.present           = 1'b1;
                  end
               end
               ssm_pkg::OP_REMOVE: begin
                  if (!is_mem) begin
                     rsp_in.status = ssm_pkg::STAT_ABSENT;
                  end else begin
                     // move last member into the freed slot
                     if (pos_rdata != last_pos) begin
                        list_we    = 1'b1;
                        list_waddr = pos_rdata[IDX_W-1:0];
                        list_wdata = list_rdata;
                        pos_we     = 1'b1;
                        pos_waddr  = list_rdata;
                        pos_wdata  = pos_rdata;
                     end
                     // clearing the valid bit marks the entry absent
                     pos_vld_in[req_ff.index] = 1'b0;
                     count_in                 = last_pos;
                  end
               end
               ssm_pkg::OP_CONTAINS: begin
                  rsp_in.present = is_mem;
               end
               default: begin
                  rsp_in.status = ssm_pkg::STAT_RANGE;
               end
            endcase
         end
         rsp_in.count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_vld_ff   <= pos_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff        <= req_data;
         pos_vld_rd_ff <= pos_vld_ff[req_data.index];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions ----
   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      count_ff <= EFF_CAP_C)
      else $error("member count above capacity");

   a_vld_count : assert property (@(posedge clock) disable iff (reset)
      $countones(pos_vld_ff) == int'(count_ff))
      else $error("valid bits disagree with member count");

   a_rsp_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.count == count_ff))
      else $error("pending result count differs from member count");

   a_wr_exec : assert property (@(posedge clock) disable iff (reset)
      (list_we || pos_we) |-> (state_ff == S_EXEC && commit))
      else $error("table write outside write-back cycle");

endmodule

`default_nettype wire

// ----- verif/ssm_result_checker.sv -----
// Result checker for the sparse set membership core: mirrors the set, predicts
// one answer per accepted request and compares it with the core's result items.
// Depends on ssm_pkg for the request/result types, opcodes and status codes.
`timescale 1ns / 1ps

module ssm_result_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire ssm_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire ssm_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    answers_owed
);

   localparam int IDX_W   = ssm_pkg::IDX_W;
   localparam int CNT_W   = ssm_pkg::CNT_W;
   localparam int DEPTH   = ssm_pkg::TABLE_DEPTH;
   localparam int EFF_CAP = (ssm_pkg::CAPACITY_DEF < DEPTH) ?
                            ssm_pkg::CAPACITY_DEF : DEPTH;

   // mirror of the set: packed member list, slot of each element, member count
   logic [IDX_W-1:0] list_mirror [DEPTH];
   logic [CNT_W-1:0] slot_of [DEPTH];
   logic [CNT_W-1:0] size_mirror;
   ssm_pkg::rsp_type answers_due [$];

   function automatic logic holds(input logic [IDX_W-1:0] e);
      return slot_of[e] < size_mirror;
   endfunction

   // applies one request to the mirror and returns the answer it must produce
   function automatic ssm_pkg::rsp_type apply_set_op(input ssm_pkg::req_type item);
      ssm_pkg::rsp_type ans;
      logic [CNT_W-1:0] slot;
      logic [CNT_W-1:0] last;
      logic [IDX_W-1:0] moved;
      ans = '0;
      ans.status = ssm_pkg::STAT_OK;
      if (item.operation == ssm_pkg::OP_READ) begin
         if ({1'b0, item.index} < size_mirror) begin
            ans.member  = list_mirror[item.index];
            ans.present = 1'b1;
         end else begin
            ans.status = ssm_pkg::STAT_RANGE;
         end
      end else if (int'(item.index) >= EFF_CAP) begin
         ans.status = ssm_pkg::STAT_RANGE;
      end else if (item.operation == ssm_pkg::OP_ADD) begin
         // duplicate check wins over the full check
         if (holds(item.index)) begin
            ans.status  = ssm_pkg::STAT_DUP;
            ans.present = 1'b1;
         end else if (int'(size_mirror) >= EFF_CAP) begin
            ans.status = ssm_pkg::STAT_FULL;
         end else begin
            list_mirror[size_mirror[IDX_W-1:0]] = item.index;
            slot_of[item.index] = size_mirror;
            size_mirror = size_mirror + CNT_W'(1);
            ans.present = 1'b1;
         end
      end else if (item.operation == ssm_pkg::OP_REMOVE) begin
         if (!holds(item.index)) begin
            ans.status = ssm_pkg::STAT_ABSENT;
         end else begin
            slot = slot_of[item.index];
            last = size_mirror - CNT_W'(1);
            if (slot != last) begin
               moved = list_mirror[last[IDX_W-1:0]];
               list_mirror[slot[IDX_W-1:0]] = moved;
               slot_of[moved] = slot;
            end
            slot_of[item.index] = ssm_pkg::ABSENT_POS;
            size_mirror = last;
         end
      end else begin
         ans.present = holds(item.index);
      end
      ans.count = size_mirror;
      return ans;
   endfunction

   task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      ssm_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            list_mirror[i] = '0;
            slot_of[i]     = ssm_pkg::ABSENT_POS;
         end
         size_mirror = '0;
         answers_due.delete();
      end else begin
         // a result never belongs to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("result item with no request outstanding");
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               check_field("status", CNT_W'(want.status), CNT_W'(rsp_data.status));
               check_field("present", CNT_W'(want.present), CNT_W'(rsp_data.present));
               check_field("member", CNT_W'(want.member), CNT_W'(rsp_data.member));
               check_field("count", want.count, rsp_data.count);
            end
         end
         if (req_valid && req_ready)
            answers_due.insert(answers_due.size(), apply_set_op(req_data));
      end
      answers_owed = answers_due.size();
   end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the sparse set membership core: clock, reset, request
// stimulus, result-side back-pressure and the verdict.
// Depends on ssm_pkg, sparse_set_membership_core and ssm_result_checker.
`timescale 1ns / 1ps

module tb;

   localparam int IDX_W = ssm_pkg::IDX_W;
   localparam int DEPTH = ssm_pkg::TABLE_DEPTH;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ssm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ssm_pkg::rsp_type rsp_data;

   int fail_count;
   int answers_owed;

   // idle odds in percent, changed between phases
   int send_idle_pct = 20;
   int recv_idle_pct = 87;

   // long receiver hold-offs: stimulus bumps the request count, the receiver
   // process notices and counts the stall down itself
   int hold_requests = 0;
   int hold_served   = 0;

   int items_sent = 0;

   logic [IDX_W-1:0] element_order [DEPTH];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sparse_set_membership_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ssm_result_checker answer_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .answers_owed (answers_owed)
   );

   // Result side: random ready at the falling edge, or a counted hold-off.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one item: optional idle gap first, then valid held with a steady
   // payload until the core takes it. Returns at the next falling edge, where
   // valid is still high so a back-to-back item needs no drop.
   task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, index: idx};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Sender goes quiet until every answer is back (the loop always waits for a
   // falling edge first, so valid is never driven twice in one step).
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(negedge clock); while (answers_owed != 0);
   endtask

   // Membership query or a read, mostly at positions likely below the count.
   task automatic send_probe(input logic [IDX_W-1:0] idx);
      if ($urandom_range(1) == 0)
         send_item(ssm_pkg::OP_CONTAINS, idx);
      else if ($urandom_range(9) < 7)
         send_item(ssm_pkg::OP_READ, IDX_W'($urandom_range(31)));
      else
         send_item(ssm_pkg::OP_READ, IDX_W'($urandom_range(255)));
   endtask

   task automatic reshuffle();
      logic [IDX_W-1:0] tmp;
      int               j;
      for (int i = DEPTH - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp              = element_order[i];
         element_order[i] = element_order[j];
         element_order[j] = tmp;
      end
   endtask

   // Every element added in random order until the set is full, then all
   // removed in another random order, which walks the swap-with-last path
   // through every slot. Elements already present just answer duplicate.
   task automatic fill_and_drain();
      for (int i = 0; i < DEPTH; i++) element_order[i] = IDX_W'(i);
      reshuffle();
      for (int i = 0; i < DEPTH; i++) begin
         send_item(ssm_pkg::OP_ADD, element_order[i]);
         if ($urandom_range(99) < 15) send_probe(IDX_W'($urandom));
      end
      // full set: further adds are refused, both list ends read back
      for (int i = 0; i < 6; i++) send_item(ssm_pkg::OP_ADD, IDX_W'($urandom));
      send_item(ssm_pkg::OP_READ, 8'd255);
      send_item(ssm_pkg::OP_READ, 8'd0);
      send_item(ssm_pkg::OP_CONTAINS, IDX_W'($urandom));
      reshuffle();
      for (int i = 0; i < DEPTH; i++) begin
         send_item(ssm_pkg::OP_REMOVE, element_order[i]);
         if ($urandom_range(99) < 15) send_probe(IDX_W'($urandom));
      end
   endtask

   // A burst of mixed operations on a window of elements; a narrow window
   // gives many hits (duplicates, real removes), a wide one many misses.
   // The add/remove balance moves the count up or down from burst to burst.
   task automatic random_burst();
      int               len;
      int               span;
      int               add_pct;
      int               rem_pct;
      int               pick;
      logic [IDX_W-1:0] base;
      logic [IDX_W-1:0] idx;
      len     = $urandom_range(60, 15);
      add_pct = $urandom_range(60, 25);
      rem_pct = $urandom_range(40, 15);
      base    = IDX_W'($urandom);
      case ($urandom_range(3))
         0: span = 3;
         1: span = 15;
         2: span = 63;
         default: span = 255;
      endcase
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         idx  = IDX_W'(base + $urandom_range(span));
         if (pick < add_pct)
            send_item(ssm_pkg::OP_ADD, idx);
         else if (pick < add_pct + rem_pct)
            send_item(ssm_pkg::OP_REMOVE, idx);
         else
            send_probe(idx);
      end
      if ($urandom_range(7) == 0) wait_for_answers();
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty set, extremes of the index, duplicates, absent
      // removes, reads past the end, removes from the first slot and the end
      send_item(ssm_pkg::OP_READ, 8'd0);          // read from the empty set
      send_item(ssm_pkg::OP_CONTAINS, 8'd0);
      send_item(ssm_pkg::OP_REMOVE, 8'd0);        // remove of an absent element
      send_item(ssm_pkg::OP_ADD, 8'd0);
      send_item(ssm_pkg::OP_ADD, 8'd255);
      send_item(ssm_pkg::OP_ADD, 8'd0);           // duplicate add
      send_item(ssm_pkg::OP_CONTAINS, 8'd255);
      send_item(ssm_pkg::OP_READ, 8'd0);
      send_item(ssm_pkg::OP_READ, 8'd1);
      send_item(ssm_pkg::OP_READ, 8'd2);          // one past the end
      send_item(ssm_pkg::OP_READ, 8'd255);
      send_item(ssm_pkg::OP_ADD, 8'h5A);
      send_item(ssm_pkg::OP_ADD, 8'hA5);
      send_item(ssm_pkg::OP_REMOVE, 8'd0);        // first slot, last member moves in
      send_item(ssm_pkg::OP_READ, 8'd0);
      send_item(ssm_pkg::OP_REMOVE, 8'h5A);       // last slot, nothing moves
      send_item(ssm_pkg::OP_REMOVE, 8'd0);        // already gone
      send_item(ssm_pkg::OP_CONTAINS, 8'd0);
      send_item(ssm_pkg::OP_REMOVE, 8'd255);
      send_item(ssm_pkg::OP_REMOVE, 8'hA5);       // set empty again
      send_item(ssm_pkg::OP_READ, 8'd0);
      send_item(ssm_pkg::OP_CONTAINS, 8'd255);

      // three phases: slow receiver, slow sender, then full speed
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 1) fill_and_drain();
         // long receiver stall while the sender keeps pushing
         if (phase == 2) hold_requests++;
         while (items_sent < 650 * (phase + 1)) random_burst();
         wait_for_answers();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #(10_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
